### src/mrbv_pkg.sv
// Shared types, constants and fixed-point helpers of the modal resonator bank voice.
// Used by every module of the block; depends on nothing.
package mrbv_pkg;

  localparam int DATA_W    = 24;
  localparam int WIDE_W    = 32;
  localparam int CMD_W     = 2;
  localparam int IDX_W     = 7;
  localparam int CNT_W     = 8;
  localparam int SCALE_W   = 23;
  localparam int DLY_W     = 10;
  localparam int DLY_N     = 4;
  localparam int DLY_SEL_W = 2;
  localparam int OP_W      = 2;
  localparam int PADDR_W   = 5;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = 3;

  localparam int MAX_MODES_DEF = 128;
  localparam int COMB_LEN_DEF  = 1024;
  localparam int COMB_TAPS_DEF = 4;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [CMD_W-1:0] CMD_RENDER = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  localparam logic [OP_W-1:0] OP_RENDER = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_MODE_COUNT = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_BANK_SCALE = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_COMB_MIX   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_DELAY_A    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_DELAY_B    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_DELAY_C    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_DELAY_D    = 3'd6;

  localparam logic [CNT_W-1:0] MODE_COUNT_RST = 8'd1;
  localparam logic [DLY_W-1:0] DELAY_RST      = 10'd101;

  // 0.001 in Q0.32 and 0.9 in Q2.22.
  localparam logic [SCALE_W-1:0] DC_LEAK  = 23'd4294967;
  localparam logic [21:0]        OUT_GAIN = 22'd3774874;

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] excitation;
    logic signed [DATA_W-1:0] direct;
    logic signed [DATA_W-1:0] b0;
    logic signed [DATA_W-1:0] a1;
    logic signed [DATA_W-1:0] a2;
    logic signed [DATA_W-1:0] gain;
  } item_t;

  typedef struct packed {
    logic [CNT_W-1:0]               mode_count;
    logic [SCALE_W-1:0]             bank_scale;
    logic [SCALE_W-1:0]             comb_mix;
    logic [DLY_N-1:0][DLY_W-1:0]    delay;
  } cfg_t;

  // Add half an LSB, then shift right with floor.
  function automatic logic signed [63:0] rnd_sh(input logic signed [63:0] v,
                                                input int unsigned sh);
    logic signed [63:0] half;
    half = 64'sd1 <<< (sh - 1);
    return (v + half) >>> sh;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
    if (v > 64'sd8388607) begin
      return 24'sh7fffff;
    end else if (v < -64'sd8388608) begin
      return 24'sh800000;
    end
    return v[23:0];
  endfunction

endpackage

### src/modal_resonator_bank_voice_unit.sv
// Render: a pop, the bank walk over the modes, then rounding, scaling and the direct mix, the
// comb taps one at a time (delay reduction, read, write back), and comb mix, DC blocker and output.
// A tap delay of COMB_LEN or more is taken down by COMB_LEN at a time. One render runs at a time.
// A clear pops and sweeps max(COMB_TAPS*COMB_LEN, MAX_MODES) entries (4096).
// Reset (synchronous, rst_n low) restores registers and runs the same sweep before items.
module modal_resonator_bank_voice_unit import mrbv_pkg::*; #(
  parameter int MAX_MODES = MAX_MODES_DEF,
  parameter int COMB_LEN  = COMB_LEN_DEF,
  parameter int COMB_TAPS = COMB_TAPS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PADDR_W-1:0]       paddr,
  input  logic [PDATA_W-1:0]       pwdata,
  output logic [PDATA_W-1:0]       prdata,
  output logic                     pready,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [CMD_W-1:0]         in_command,
  input  logic [IDX_W-1:0]         in_mode_index,
  input  logic signed [DATA_W-1:0] in_excitation,
  input  logic signed [DATA_W-1:0] in_direct_mix,
  input  logic signed [DATA_W-1:0] in_coef_input,
  input  logic signed [DATA_W-1:0] in_coef_first,
  input  logic signed [DATA_W-1:0] in_coef_second,
  input  logic signed [DATA_W-1:0] in_mode_gain,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_sample_out
);

  // The register file. Each register sits at byte address 4*i; the two low address
  // bits are ignored. A write lands in the access phase, and pready is tied high.
  // Coefficient memories are not cleared; a mode must be loaded before it is rendered.
  cfg_t                  cfg_r, cfg_nxt;
  logic [REG_IDX_W-1:0]  reg_idx;
  logic                  reg_wr;

  // Queue between the front end and the engine.
  item_t                 q_item;
  logic                  q_valid;
  logic                  q_pop;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign reg_wr  = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (reg_wr) begin
      case (reg_idx)
        REG_MODE_COUNT: cfg_nxt.mode_count = pwdata[CNT_W-1:0];
        REG_BANK_SCALE: cfg_nxt.bank_scale = pwdata[SCALE_W-1:0];
        REG_COMB_MIX:   cfg_nxt.comb_mix   = pwdata[SCALE_W-1:0];
        REG_DELAY_A:    cfg_nxt.delay[0]   = pwdata[DLY_W-1:0];
        REG_DELAY_B:    cfg_nxt.delay[1]   = pwdata[DLY_W-1:0];
        REG_DELAY_C:    cfg_nxt.delay[2]   = pwdata[DLY_W-1:0];
        REG_DELAY_D:    cfg_nxt.delay[3]   = pwdata[DLY_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MODE_COUNT: prdata = PDATA_W'(cfg_r.mode_count);
      REG_BANK_SCALE: prdata = PDATA_W'(cfg_r.bank_scale);
      REG_COMB_MIX:   prdata = PDATA_W'(cfg_r.comb_mix);
      REG_DELAY_A:    prdata = PDATA_W'(cfg_r.delay[0]);
      REG_DELAY_B:    prdata = PDATA_W'(cfg_r.delay[1]);
      REG_DELAY_C:    prdata = PDATA_W'(cfg_r.delay[2]);
      REG_DELAY_D:    prdata = PDATA_W'(cfg_r.delay[3]);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode_count <= MODE_COUNT_RST;
      cfg_r.bank_scale <= '0;
      cfg_r.comb_mix   <= '0;
      cfg_r.delay      <= {DLY_N{DELAY_RST}};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // The front end takes every input beat it has room for. Unused commands and loads
  // to a mode beyond the bank are accepted and dropped there, so the engine sees
  // only render, load and clear work.
  mrbv_front #(
    .MAX_MODES (MAX_MODES)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_mode_index  (in_mode_index),
    .in_excitation  (in_excitation),
    .in_direct_mix  (in_direct_mix),
    .in_coef_input  (in_coef_input),
    .in_coef_first  (in_coef_first),
    .in_coef_second (in_coef_second),
    .in_mode_gain   (in_mode_gain),
    .q_item         (q_item),
    .q_valid        (q_valid),
    .q_pop          (q_pop)
  );

  // The engine walks the modes through a five-stage pipeline (memory read, three
  // products, round and history write back, gain product, accumulate), applies the bank
  // scale and direct mix, runs the comb taps one at a time over the single comb memory,
  // and finishes with the comb mix, DC blocker and output gain, one multiply each.
  // Its output register frees the queue side while a sample waits to be taken.
  mrbv_engine #(
    .MAX_MODES (MAX_MODES),
    .COMB_LEN  (COMB_LEN),
    .COMB_TAPS (COMB_TAPS)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_item     (q_item),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_sample (out_sample_out)
  );

endmodule

### src/mrbv_front.sv
// Front end: accepts input beats, sorts out commands that do nothing, queues the rest.
// Depends on mrbv_pkg.
module mrbv_front import mrbv_pkg::*; #(
  parameter int MAX_MODES = MAX_MODES_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [CMD_W-1:0]         in_command,
  input  logic [IDX_W-1:0]         in_mode_index,
  input  logic signed [DATA_W-1:0] in_excitation,
  input  logic signed [DATA_W-1:0] in_direct_mix,
  input  logic signed [DATA_W-1:0] in_coef_input,
  input  logic signed [DATA_W-1:0] in_coef_first,
  input  logic signed [DATA_W-1:0] in_coef_second,
  input  logic signed [DATA_W-1:0] in_mode_gain,
  output item_t                    q_item,
  output logic                     q_valid,
  input  logic                     q_pop
);

  localparam int QP_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

  item_t            q_mem [QUEUE_DEPTH];
  logic [QP_W-1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QC_W-1:0]  cnt_r, cnt_nxt;
  logic             keep;
  logic             push;
  item_t            in_item;

  always_comb begin
    in_item.op         = OP_RENDER;
    in_item.idx        = in_mode_index;
    in_item.excitation = in_excitation;
    in_item.direct     = in_direct_mix;
    in_item.b0         = in_coef_input;
    in_item.a1         = in_coef_first;
    in_item.a2         = in_coef_second;
    in_item.gain       = in_mode_gain;
    keep               = 1'b0;
    case (in_command)
      CMD_RENDER: begin
        keep = 1'b1;
      end
      CMD_LOAD: begin
        in_item.op = OP_LOAD;
        keep = ((IDX_W + 2)'(in_mode_index) < (IDX_W + 2)'(MAX_MODES));
      end
      CMD_CLEAR: begin
        in_item.op = OP_CLEAR;
        keep = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_ready = (cnt_r != QC_W'(QUEUE_DEPTH));
  assign push     = in_valid && in_ready && keep;
  assign q_valid  = (cnt_r != '0);
  assign q_item   = q_mem[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (q_pop && q_valid) begin
      rp_nxt = (rp_r == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !(q_pop && q_valid)) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && q_pop && q_valid) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wp_r] <= in_item;
    end
  end

endmodule

### src/mrbv_engine.sv
// Back end: resonator bank pipeline, comb taps, DC blocker and the output register.
// Holds the coefficient, history and comb memories. Depends on mrbv_pkg.
module mrbv_engine import mrbv_pkg::*; #(
  parameter int MAX_MODES = MAX_MODES_DEF,
  parameter int COMB_LEN  = COMB_LEN_DEF,
  parameter int COMB_TAPS = COMB_TAPS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cfg_t                     cfg,
  input  item_t                    q_item,
  input  logic                     q_valid,
  output logic                     q_pop,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_sample
);

  localparam int MI_W   = (MAX_MODES > 1) ? $clog2(MAX_MODES) : 1;
  localparam int MN_W   = $clog2(MAX_MODES + 1);
  localparam int COMB_N = COMB_TAPS * COMB_LEN;
  localparam int CA_W   = $clog2(COMB_N);
  localparam int CLR_N  = (COMB_N > MAX_MODES) ? COMB_N : MAX_MODES;
  localparam int CL_W   = $clog2(CLR_N + 1);
  localparam int P_W    = $clog2(COMB_LEN);
  localparam int LN_W   = $clog2(COMB_LEN + 1);
  localparam int M_W    = (DLY_W > LN_W) ? DLY_W : LN_W;
  localparam int T_W    = $clog2(COMB_TAPS + 1);
  localparam int SUM_W  = DATA_W + $clog2(COMB_TAPS);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_BANK  = 4'd2;
  localparam logic [3:0] S_ROUND = 4'd3;
  localparam logic [3:0] S_SMUL  = 4'd4;
  localparam logic [3:0] S_SRND  = 4'd5;
  localparam logic [3:0] S_MIX   = 4'd6;
  localparam logic [3:0] S_TMOD  = 4'd7;
  localparam logic [3:0] S_TRD   = 4'd8;
  localparam logic [3:0] S_TWR   = 4'd9;
  localparam logic [3:0] S_CMUL  = 4'd10;
  localparam logic [3:0] S_CADD  = 4'd11;
  localparam logic [3:0] S_DMUL  = 4'd12;
  localparam logic [3:0] S_DADD  = 4'd13;
  localparam logic [3:0] S_OMUL  = 4'd14;
  localparam logic [3:0] S_OUT   = 4'd15;

  // Memories: {a1, a2}, {b0, gain}, {y1, y2} per mode, and the comb lines.
  logic [2*DATA_W-1:0]      feed_mem [MAX_MODES];
  logic [2*DATA_W-1:0]      mixc_mem [MAX_MODES];
  logic [2*WIDE_W-1:0]      hist_mem [MAX_MODES];
  logic signed [DATA_W-1:0] comb_mem [COMB_N];

  logic [2*DATA_W-1:0]      feed_rd_r, mixc_rd_r;
  logic [2*WIDE_W-1:0]      hist_rd_r;
  logic signed [DATA_W-1:0] comb_rd_r;

  logic [3:0]               state_r, state_nxt;
  logic [CL_W-1:0]          clr_r, clr_nxt;
  logic [MN_W-1:0]          iss_r, iss_nxt, n_r, n_nxt;
  logic                     v1_r, v2_r, v3_r, v4_r, v1_nxt;
  logic [MI_W-1:0]          m1_r, m2_r;
  logic signed [47:0]       pb_r;
  logic signed [55:0]       pa1_r, pa2_r, p4_r;
  logic signed [WIDE_W-1:0] y1o_r, y3_r, ynew;
  logic signed [DATA_W-1:0] g2_r, g3_r;
  logic signed [63:0]       acc_r, acc_nxt;
  logic signed [DATA_W-1:0] x_r, x_nxt, direct_r, direct_nxt;
  logic signed [WIDE_W-1:0] res_r, res_nxt, mix_r, mix_nxt, dc_r, dc_nxt;
  logic signed [63:0]       prod_r, prod_nxt;
  logic [T_W-1:0]           tap_r, tap_nxt;
  logic [CA_W-1:0]          base_r, base_nxt;
  logic [M_W-1:0]           dm_r, dm_nxt;
  logic [P_W-1:0]           pos_r, pos_nxt;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_sample_r, out_sample_nxt;

  logic                     hist_we, coef_we, comb_we;
  logic [MI_W-1:0]          hist_wa;
  logic [2*WIDE_W-1:0]      hist_wd;
  logic [CA_W-1:0]          comb_wa, comb_ra;
  logic signed [DATA_W-1:0] comb_wd;
  logic [M_W:0]             pos_w, rd_w;

  logic signed [55:0]           mul_scale;
  logic signed [SUM_W+SCALE_W:0] mul_comb;
  logic signed [WIDE_W:0]       dc_diff, out_diff;
  logic signed [WIDE_W+SCALE_W+1:0] mul_leak;
  logic signed [WIDE_W+22:0]    mul_out;

  assign q_pop      = (state_r == S_IDLE) && q_valid;
  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

  // New y of the mode in the second pipeline stage.
  assign ynew = sat32(rnd_sh(64'(pb_r) + 64'(pa1_r) + 64'(pa2_r), 22));

  // Read position of the current tap: write position minus the reduced delay.
  assign pos_w   = (M_W + 1)'(pos_r);
  assign rd_w    = (pos_w >= (M_W + 1)'(dm_r)) ? pos_w - (M_W + 1)'(dm_r)
                                               : pos_w + (M_W + 1)'(COMB_LEN) - (M_W + 1)'(dm_r);
  assign comb_ra = base_r + CA_W'(rd_w[P_W-1:0]);

  assign mul_scale = res_r * $signed({1'b0, cfg.bank_scale});
  assign mul_comb  = sum_r * $signed({1'b0, cfg.comb_mix});
  assign dc_diff   = {mix_r[WIDE_W-1], mix_r} - {dc_r[WIDE_W-1], dc_r};
  assign mul_leak  = dc_diff * $signed({1'b0, DC_LEAK});
  assign out_diff  = {mix_r[WIDE_W-1], mix_r} - {dc_r[WIDE_W-1], dc_r};
  assign mul_out   = out_diff * $signed({1'b0, OUT_GAIN});

  // Memory write port selection.
  always_comb begin
    hist_we = 1'b0;
    hist_wa = m2_r;
    hist_wd = {ynew, y1o_r};
    coef_we = 1'b0;
    comb_we = 1'b0;
    comb_wa = base_r + CA_W'(pos_r);
    comb_wd = sat24(64'(mix_r) + rnd_sh(64'(comb_rd_r), 2));
    if (state_r == S_CLEAR) begin
      hist_we = (clr_r < CL_W'(MAX_MODES));
      hist_wa = clr_r[MI_W-1:0];
      hist_wd = '0;
      comb_we = (clr_r < CL_W'(COMB_N));
      comb_wa = clr_r[CA_W-1:0];
      comb_wd = '0;
    end else if (q_pop && (q_item.op == OP_LOAD)) begin
      hist_we = 1'b1;
      hist_wa = MI_W'(q_item.idx);
      hist_wd = '0;
      coef_we = 1'b1;
    end else if (v2_r) begin
      hist_we = 1'b1;
    end else if (state_r == S_TWR) begin
      comb_we = 1'b1;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    iss_nxt        = iss_r;
    n_nxt          = n_r;
    v1_nxt         = 1'b0;
    acc_nxt        = v4_r ? acc_r + 64'(p4_r) : acc_r;
    x_nxt          = x_r;
    direct_nxt     = direct_r;
    res_nxt        = res_r;
    mix_nxt        = mix_r;
    dc_nxt         = dc_r;
    prod_nxt       = prod_r;
    tap_nxt        = tap_r;
    base_nxt       = base_r;
    dm_nxt         = dm_r;
    pos_nxt        = pos_r;
    sum_nxt        = sum_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_sample_nxt = out_sample_r;
    case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == CL_W'(CLR_N - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          case (q_item.op)
            OP_RENDER: begin
              x_nxt      = q_item.excitation;
              direct_nxt = q_item.direct;
              n_nxt      = ((CNT_W + 1)'(cfg.mode_count) > (CNT_W + 1)'(MAX_MODES))
                           ? MN_W'(MAX_MODES) : MN_W'(cfg.mode_count);
              iss_nxt    = '0;
              acc_nxt    = '0;
              state_nxt  = S_BANK;
            end
            OP_CLEAR: begin
              clr_nxt   = '0;
              pos_nxt   = '0;
              dc_nxt    = '0;
              state_nxt = S_CLEAR;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_BANK: begin
        if (iss_r != n_r) begin
          v1_nxt  = 1'b1;
          iss_nxt = iss_r + 1'b1;
        end else if (!v1_r && !v2_r && !v3_r && !v4_r) begin
          state_nxt = S_ROUND;
        end
      end
      S_ROUND: begin
        res_nxt   = sat32(rnd_sh(acc_r, 22));
        state_nxt = S_SMUL;
      end
      S_SMUL: begin
        prod_nxt  = 64'(mul_scale);
        state_nxt = S_SRND;
      end
      S_SRND: begin
        res_nxt   = sat32(rnd_sh(prod_r, 22));
        state_nxt = S_MIX;
      end
      S_MIX: begin
        mix_nxt   = sat32(64'(res_r) + 64'(direct_r));
        tap_nxt   = '0;
        base_nxt  = '0;
        sum_nxt   = '0;
        dm_nxt    = M_W'(cfg.delay[0]);
        state_nxt = S_TMOD;
      end
      S_TMOD: begin
        if (dm_r >= M_W'(COMB_LEN)) begin
          dm_nxt = dm_r - M_W'(COMB_LEN);
        end else begin
          state_nxt = S_TRD;
        end
      end
      S_TRD: begin
        state_nxt = S_TWR;
      end
      S_TWR: begin
        sum_nxt = sum_r + SUM_W'(comb_rd_r);
        if (tap_r == T_W'(COMB_TAPS - 1)) begin
          pos_nxt   = (pos_r == P_W'(COMB_LEN - 1)) ? '0 : pos_r + 1'b1;
          state_nxt = S_CMUL;
        end else begin
          tap_nxt   = tap_r + 1'b1;
          base_nxt  = base_r + CA_W'(COMB_LEN);
          dm_nxt    = M_W'(cfg.delay[DLY_SEL_W'(tap_r + 1'b1)]);
          state_nxt = S_TMOD;
        end
      end
      S_CMUL: begin
        prod_nxt  = 64'(mul_comb);
        state_nxt = S_CADD;
      end
      S_CADD: begin
        mix_nxt   = sat32(64'(mix_r) + rnd_sh(prod_r, 22));
        state_nxt = S_DMUL;
      end
      S_DMUL: begin
        prod_nxt  = 64'(mul_leak);
        state_nxt = S_DADD;
      end
      S_DADD: begin
        dc_nxt    = sat32(64'(dc_r) + rnd_sh(prod_r, 32));
        state_nxt = S_OMUL;
      end
      S_OMUL: begin
        prod_nxt  = 64'(mul_out);
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_sample_nxt = sat24(rnd_sh(prod_r, 22));
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      iss_r       <= '0;
      n_r         <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      tap_r       <= '0;
      base_r      <= '0;
      pos_r       <= '0;
      dc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      iss_r       <= iss_nxt;
      n_r         <= n_nxt;
      v1_r        <= v1_nxt;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      tap_r       <= tap_nxt;
      base_r      <= base_nxt;
      pos_r       <= pos_nxt;
      dc_r        <= dc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers and the bank pipeline.
  always_ff @(posedge clk) begin
    acc_r        <= acc_nxt;
    x_r          <= x_nxt;
    direct_r     <= direct_nxt;
    res_r        <= res_nxt;
    mix_r        <= mix_nxt;
    prod_r       <= prod_nxt;
    dm_r         <= dm_nxt;
    sum_r        <= sum_nxt;
    out_sample_r <= out_sample_nxt;
    m1_r         <= iss_r[MI_W-1:0];
    m2_r         <= m1_r;
    pb_r         <= $signed(mixc_rd_r[2*DATA_W-1:DATA_W]) * x_r;
    pa1_r        <= $signed(feed_rd_r[2*DATA_W-1:DATA_W]) * $signed(hist_rd_r[2*WIDE_W-1:WIDE_W]);
    pa2_r        <= $signed(feed_rd_r[DATA_W-1:0]) * $signed(hist_rd_r[WIDE_W-1:0]);
    y1o_r        <= hist_rd_r[2*WIDE_W-1:WIDE_W];
    g2_r         <= mixc_rd_r[DATA_W-1:0];
    y3_r         <= ynew;
    g3_r         <= g2_r;
    p4_r         <= y3_r * g3_r;
  end

  always_ff @(posedge clk) begin
    if (coef_we) begin
      feed_mem[MI_W'(q_item.idx)] <= {q_item.a1, q_item.a2};
      mixc_mem[MI_W'(q_item.idx)] <= {q_item.b0, q_item.gain};
    end
    feed_rd_r <= feed_mem[iss_r[MI_W-1:0]];
    mixc_rd_r <= mixc_mem[iss_r[MI_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_wa] <= hist_wd;
    end
    hist_rd_r <= hist_mem[iss_r[MI_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (comb_we) begin
      comb_mem[comb_wa] <= comb_wd;
    end
    comb_rd_r <= comb_mem[comb_ra];
  end

endmodule

### tb/sv/modal_resonator_bank_voice_unit_test.sv
// Self-checking testbench of modal_resonator_bank_voice_unit: stimulus, predictor and checker.
// Depends on mrbv_pkg and the block's RTL only.
`timescale 1ns / 1ps

module modal_resonator_bank_voice_unit_test;
  import mrbv_pkg::*;

  // Fixed-point constants of the output stage: 0.001 in Q0.32 and 0.9 in Q2.22.
  localparam longint LEAK_Q32  = 64'sd4294967;
  localparam longint GAIN_Q22  = 64'sd3774874;
  localparam int     N_MODES   = 128;
  localparam int     DLINE_LEN = 1024;
  localparam int     N_TAPS    = 4;
  // Command code that the block accepts and ignores.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  // A clear sweeps 4096 entries, and up to three clears can be in flight at once.
  localparam int     SETTLE_CYCLES = 13000;
  localparam int     STALL_LIMIT   = 60000;

  logic                     clk;
  logic                     rst_n;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [PADDR_W-1:0]       paddr;
  logic [PDATA_W-1:0]       pwdata;
  logic [PDATA_W-1:0]       prdata;
  logic                     pready;
  logic                     in_valid;
  logic                     in_ready;
  logic [CMD_W-1:0]         in_command;
  logic [IDX_W-1:0]         in_mode_index;
  logic signed [DATA_W-1:0] in_excitation;
  logic signed [DATA_W-1:0] in_direct_mix;
  logic signed [DATA_W-1:0] in_coef_input;
  logic signed [DATA_W-1:0] in_coef_first;
  logic signed [DATA_W-1:0] in_coef_second;
  logic signed [DATA_W-1:0] in_mode_gain;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [DATA_W-1:0] out_sample_out;

  modal_resonator_bank_voice_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_mode_index  (in_mode_index),
    .in_excitation  (in_excitation),
    .in_direct_mix  (in_direct_mix),
    .in_coef_input  (in_coef_input),
    .in_coef_first  (in_coef_first),
    .in_coef_second (in_coef_second),
    .in_mode_gain   (in_mode_gain),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out)
  );

  // Shadow copy of the voice: configuration, coefficient tables and running state.
  logic [CNT_W-1:0]   sh_mode_count;
  logic [SCALE_W-1:0] sh_bank_scale;
  logic [SCALE_W-1:0] sh_comb_mix;
  logic [DLY_W-1:0]   sh_delay [N_TAPS];
  longint             sh_b0 [N_MODES];
  longint             sh_a1 [N_MODES];
  longint             sh_a2 [N_MODES];
  longint             sh_gain [N_MODES];
  longint             sh_y1 [N_MODES];
  longint             sh_y2 [N_MODES];
  longint             sh_dline [N_TAPS*DLINE_LEN];
  int unsigned        sh_wpos;
  longint             sh_dc;

  logic signed [DATA_W-1:0] expected_samples[$];
  int  error_count;
  bit  tx_idle_on;
  bit  rx_idle_on;
  int  rx_hold_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint round_shift(longint v, int sh);
    return (v + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint clamp_bits(longint v, int bits);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic void clear_voice_state();
    foreach (sh_y1[i]) begin
      sh_y1[i] = 0;
      sh_y2[i] = 0;
    end
    foreach (sh_dline[i]) sh_dline[i] = 0;
    sh_wpos = 0;
    sh_dc   = 0;
  endfunction

  // Advances the shadow voice by one accepted beat and queues the sample a render produces.
  function automatic void render_voice(item_t it);
    longint x, direct, acc, s, yv, res, mix, sum, v, diff, y;
    int n;
    int unsigned d, rd;
    if (it.op == CMD_LOAD) begin
      sh_b0[it.idx]   = longint'($signed(it.b0));
      sh_a1[it.idx]   = longint'($signed(it.a1));
      sh_a2[it.idx]   = longint'($signed(it.a2));
      sh_gain[it.idx] = longint'($signed(it.gain));
      sh_y1[it.idx]   = 0;
      sh_y2[it.idx]   = 0;
      return;
    end
    if (it.op == CMD_CLEAR) begin
      clear_voice_state();
      return;
    end
    if (it.op != CMD_RENDER) return;
    x      = longint'($signed(it.excitation));
    direct = longint'($signed(it.direct));
    n = (sh_mode_count > N_MODES) ? N_MODES : int'(sh_mode_count);
    acc = 0;
    for (int i = 0; i < n; i++) begin
      s  = sh_b0[i] * x + sh_a1[i] * sh_y1[i] + sh_a2[i] * sh_y2[i];
      yv = clamp_bits(round_shift(s, 22), 32);
      sh_y2[i] = sh_y1[i];
      sh_y1[i] = yv;
      acc += yv * sh_gain[i];
    end
    res = clamp_bits(round_shift(acc, 22), 32);
    res = clamp_bits(round_shift(res * longint'(sh_bank_scale), 22), 32);
    mix = clamp_bits(res + direct, 32);
    sum = 0;
    for (int t = 0; t < N_TAPS; t++) begin
      d  = int'(sh_delay[t % 4]) % DLINE_LEN;
      rd = (sh_wpos + DLINE_LEN - d) % DLINE_LEN;
      v  = sh_dline[t*DLINE_LEN + rd];
      sum += v;
      sh_dline[t*DLINE_LEN + sh_wpos] = clamp_bits(mix + round_shift(v, 2), 24);
    end
    sh_wpos = (sh_wpos + 1) % DLINE_LEN;
    mix  = clamp_bits(mix + round_shift(sum * longint'(sh_comb_mix), 22), 32);
    diff = mix - sh_dc;
    sh_dc = clamp_bits(sh_dc + round_shift(diff * LEAK_Q32, 32), 32);
    y = clamp_bits(round_shift((mix - sh_dc) * GAIN_Q22, 22), 24);
    expected_samples.push_back(y[DATA_W-1:0]);
  endfunction

  task automatic report_mismatch(string what, longint want, longint got);
    $display("mismatch at %0t: %s expected %0d got %0d", $time, what, want, got);
    error_count++;
  endtask

  // Sends one beat and holds it until the block takes it; may then idle for a burst.
  task automatic send_beat(item_t it);
    in_valid       <= 1'b1;
    in_command     <= it.op;
    in_mode_index  <= it.idx;
    in_excitation  <= it.excitation;
    in_direct_mix  <= it.direct;
    in_coef_input  <= it.b0;
    in_coef_first  <= it.a1;
    in_coef_second <= it.a2;
    in_mode_gain   <= it.gain;
    do @(posedge clk); while (!(in_valid && in_ready));
    render_voice(it);
    if (tx_idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // Waits until every sample has arrived and any clear sweep has had time to finish.
  task automatic drain_voice();
    in_valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_MODE_COUNT: sh_mode_count = value[CNT_W-1:0];
      REG_BANK_SCALE: sh_bank_scale = value[SCALE_W-1:0];
      REG_COMB_MIX:   sh_comb_mix   = value[SCALE_W-1:0];
      REG_DELAY_A:    sh_delay[0]   = value[DLY_W-1:0];
      REG_DELAY_B:    sh_delay[1]   = value[DLY_W-1:0];
      REG_DELAY_C:    sh_delay[2]   = value[DLY_W-1:0];
      REG_DELAY_D:    sh_delay[3]   = value[DLY_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_setting(int count, int scale, int cmix, int da, int db, int dc, int dd);
    drain_voice();
    write_reg(REG_MODE_COUNT, count);
    write_reg(REG_BANK_SCALE, scale);
    write_reg(REG_COMB_MIX, cmix);
    write_reg(REG_DELAY_A, da);
    write_reg(REG_DELAY_B, db);
    write_reg(REG_DELAY_C, dc);
    write_reg(REG_DELAY_D, dd);
  endtask

  function automatic item_t make_render(int ex, int dm);
    item_t it;
    it = '0;
    it.op = CMD_RENDER;
    it.excitation = DATA_W'(ex);
    it.direct = DATA_W'(dm);
    it.idx = IDX_W'($urandom);
    it.b0 = DATA_W'($urandom);
    return it;
  endfunction

  // Mostly a decaying resonance with moderate gains, sometimes raw full-range coefficients.
  function automatic item_t make_load(int idx);
    item_t it;
    int a2mag;
    it = '0;
    it.op  = CMD_LOAD;
    it.idx = IDX_W'(idx);
    it.excitation = DATA_W'($urandom);
    it.direct = DATA_W'($urandom);
    if ($urandom_range(0, 5) == 0) begin
      it.b0 = DATA_W'($urandom);
      it.a1 = DATA_W'($urandom);
      it.a2 = DATA_W'($urandom);
      it.gain = DATA_W'($urandom);
    end else begin
      a2mag = $urandom_range(3000000, 4190000);
      it.a2 = DATA_W'(-a2mag);
      it.a1 = DATA_W'(int'($urandom_range(0, 2 * a2mag)) - a2mag);
      it.b0 = DATA_W'(int'($urandom_range(0, 800000)) - 400000);
      it.gain = DATA_W'(int'($urandom_range(0, 8388607)) - 4194304);
    end
    return it;
  endfunction

  function automatic item_t make_random_beat();
    int pick;
    pick = $urandom_range(0, 199);
    if (pick < 160) begin
      if ($urandom_range(0, 3) == 0) return make_render($urandom, $urandom);
      return make_render(int'($urandom_range(0, 2000000)) - 1000000,
                         int'($urandom_range(0, 2000000)) - 1000000);
    end
    if (pick < 194) return make_load($urandom_range(0, N_MODES - 1));
    if (pick < 197) begin
      make_random_beat = make_render(0, 0);
      make_random_beat.op = CMD_UNUSED;
      return make_random_beat;
    end
    make_random_beat = make_render($urandom, $urandom);
    make_random_beat.op = CMD_CLEAR;
    return make_random_beat;
  endfunction

  // Extremes of the sample fields, the unused command and a clear, at full bank and comb gain.
  task automatic test_directed_extremes();
    item_t it;
    send_beat(make_load(0));
    write_setting(1, 8388607, 8388607, 1, 1, 1023, 1023);
    send_beat(make_render(8388607, 8388607));
    send_beat(make_render(-8388608, -8388608));
    send_beat(make_render(8388607, -8388608));
    send_beat(make_render(0, 0));
    send_beat(make_render(-1, 1));
    it = make_render(12345, 0);
    it.op = CMD_UNUSED;
    send_beat(it);
    send_beat(make_render(-8388608, 8388607));
    it = make_load(0);
    it.b0 = 24'sh7fffff;
    it.a1 = 24'sh7fffff;
    it.a2 = 24'sh800000;
    it.gain = 24'sh7fffff;
    send_beat(it);
    send_beat(make_render(8388607, 0));
    send_beat(make_render(8388607, 0));
    it.op = CMD_CLEAR;
    send_beat(it);
    send_beat(make_render(-8388608, 0));
    send_beat(make_render(4096, -4096));
  endtask

  // Every mode gets coefficients before any setting renders more than one.
  task automatic test_load_all_modes();
    for (int m = 0; m < N_MODES; m++) send_beat(make_load(m));
  endtask

  // Several settings, extremes included: no modes, a count past the bank size, zero delays.
  task automatic test_register_settings();
    write_setting(0, 4194304, 2097152, 0, 0, 0, 0);
    repeat (30) send_beat(make_random_beat());
    write_setting(255, 8388607, 0, 1023, 512, 3, 1);
    repeat (20) send_beat(make_random_beat());
    write_setting(128, 32768, 8388607, 1, 2, 3, 4);
    repeat (20) send_beat(make_random_beat());
    write_setting(7, 1000000, 1048576, 17, 29, 31, 37);
    repeat (60) send_beat(make_random_beat());
  endtask

  // The receiver holds off long enough for the block to fill and stall its input,
  // then the sender waits for every sample before going on.
  task automatic test_backpressure();
    rx_hold_cycles = 1500;
    repeat (12) send_beat(make_render($urandom, $urandom));
    in_valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (8) send_beat(make_render($urandom, $urandom));
  endtask

  task automatic test_random_stream();
    write_setting(12, 600000, 3000000, 101, 257, 389, 641);
    repeat (500) send_beat(make_random_beat());
    write_setting($urandom_range(1, 24), $urandom_range(0, 8388607), $urandom_range(0, 8388607),
                  $urandom_range(1, 1023), $urandom_range(1, 1023), $urandom_range(1, 1023),
                  $urandom_range(1, 1023));
    repeat (400) send_beat(make_random_beat());
    // Closing stretch runs at full rate on both sides.
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (300) send_beat(make_random_beat());
  endtask

  // Checker and receiver: compares each accepted sample, then picks the next ready level.
  initial begin
    int burst;
    logic signed [DATA_W-1:0] want;
    burst = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          report_mismatch("unexpected sample_out", 0, out_sample_out);
        end else begin
          want = expected_samples.pop_front();
          if (want !== out_sample_out) report_mismatch("sample_out", want, out_sample_out);
        end
      end
      if (rx_hold_cycles > 0) begin
        rx_hold_cycles--;
        out_ready <= 1'b0;
      end else if (burst > 0) begin
        burst--;
        out_ready <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 14) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles in which no beat, sample or register access moves.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || psel) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("timeout: no progress for %0d cycles", STALL_LIMIT);
        $display("** modal_resonator_bank_voice_unit: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    error_count    = 0;
    tx_idle_on     = 1'b1;
    rx_idle_on     = 1'b1;
    rx_hold_cycles = 0;
    rst_n          = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_valid       = 1'b0;
    in_command     = CMD_RENDER;
    in_mode_index  = '0;
    in_excitation  = '0;
    in_direct_mix  = '0;
    in_coef_input  = '0;
    in_coef_first  = '0;
    in_coef_second = '0;
    in_mode_gain   = '0;
    out_ready      = 1'b0;
    sh_mode_count  = MODE_COUNT_RST;
    sh_bank_scale  = '0;
    sh_comb_mix    = '0;
    foreach (sh_delay[t]) sh_delay[t] = DELAY_RST;
    foreach (sh_b0[i]) begin
      sh_b0[i] = 0;
      sh_a1[i] = 0;
      sh_a2[i] = 0;
      sh_gain[i] = 0;
    end
    clear_voice_state();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_extremes();
    test_load_all_modes();
    test_register_settings();
    test_backpressure();
    test_random_stream();

    in_valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (error_count == 0) begin
      $display("** modal_resonator_bank_voice_unit: PASSED **");
    end else begin
      $display("** modal_resonator_bank_voice_unit: FAILED **");
    end
    $finish;
  end

endmodule
